[design/lcp_pkg.sv]
// Package for the line clipper: fixed-point types, item structs and Q16.16 helpers.
// Used by every module of the line_clip_and_project block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcp_pkg;

  // Divider lanes and quotient bits per divider pass.
  localparam int NLANE     = 4;
  localparam int DIV_STEPS = 32;
  // Width of the field-of-view tangent register.
  localparam int TW        = 23;

  typedef logic signed [31:0] q_t;
  typedef logic signed [63:0] p64_t;

  localparam q_t Q_ONE   = 32'sd65536;
  localparam q_t Q_MAX   = 32'sh7fff_ffff;
  localparam q_t Q_MIN   = q_t'(32'h8000_0000);
  localparam q_t Z_NEAR  = -32'sd65536;
  localparam q_t Z_FAR   = -32'sd327680;
  localparam q_t FAR_DIV = 32'sd327680;
  localparam logic [TW-1:0] FOV_RESET = TW'(65536);

  typedef struct packed {
    q_t x;
    q_t y;
    q_t z;
  } vec_t;

  // Input item: one 3D segment.
  typedef struct packed {
    q_t   start_x;
    q_t   start_y;
    q_t   start_z;
    q_t   end_x;
    q_t   end_y;
    q_t   end_z;
    logic last_line;
  } lcp_in_t;

  // Result item: the clipped, projected segment.
  typedef struct packed {
    logic visible;
    q_t   out_x0;
    q_t   out_y0;
    q_t   out_x1;
    q_t   out_y1;
    logic batch_end;
  } lcp_out_t;

  // One divider lane: numerator and denominator.
  typedef struct packed {
    q_t num;
    q_t den;
  } lane_t;

  // Per-lane sign and special-case flags carried through the divider.
  typedef struct packed {
    logic neg;
    logic dz;
    logic ovf;
    logic apos;
    logic aneg;
  } dmeta_t;

  // Segment context that travels down the pipeline with each item.
  typedef struct packed {
    logic            last;
    logic            ok;
    vec_t [1:0]      pt;
    vec_t [1:0]      dv;
    logic [TW-1:0]   t;
    logic [1:0]      zn;
    logic [1:0]      zf;
    logic [1:0]      cl;
    logic [1:0]      kp;
    q_t [1:0]        cx;
    q_t [1:0]        cy;
    q_t [1:0]        tmp;
    p64_t [1:0]      pa;
    p64_t [1:0]      pb;
  } ctx_t;

  // Saturate a 33-bit sum to the Q16.16 range.
  function automatic q_t sat33(input logic signed [32:0] v);
    q_t r;
    if (v > 33'sd2147483647) begin
      r = Q_MAX;
    end else if (v < -33'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic q_t qadd(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    return sat33(s);
  endfunction

  function automatic q_t qsub(input q_t a, input q_t b);
    logic signed [32:0] s;
    s = 33'(a) - 33'(b);
    return sat33(s);
  endfunction

  function automatic q_t qneg(input q_t a);
    logic signed [32:0] s;
    s = -33'(a);
    return sat33(s);
  endfunction

  // Full product of two Q16.16 values; scaled later by qmf.
  function automatic p64_t qprod(input q_t a, input q_t b);
    return p64_t'(a) * p64_t'(b);
  endfunction

  // Scale a product back to Q16.16, truncating toward zero, and saturate.
  function automatic q_t qmf(input p64_t p);
    p64_t s;
    q_t   r;
    s = (p + (p[63] ? 64'sd65535 : 64'sd0)) >>> 16;
    if (s > 64'sd2147483647) begin
      r = Q_MAX;
    end else if (s < -64'sd2147483648) begin
      r = Q_MIN;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  function automatic q_t tq(input logic [TW-1:0] t);
    return q_t'({{(32-TW){1'b0}}, t});
  endfunction

  function automatic q_t kval(input logic kp, input q_t t);
    return kp ? t : -t;
  endfunction

  function automatic logic outside(input q_t u, input q_t t);
    return (u > t) || (u < -t);
  endfunction

  function automatic logic both_out(input q_t u, input q_t v, input q_t t);
    return ((u > t) && (v > t)) || ((u < -t) && (v < -t));
  endfunction

endpackage

`default_nettype wire

[design/line_clip_and_project.sv]
// Throughput: one item per cycle while no result is held under out_stall_i.
// Seven divider passes of 35 stages each set the depth.
// The whole pipeline advances together and holds while a result waits under out_stall_i.
// Reset clears all valid bits and loads the field-of-view tangent with 1.0.
// Top level: segment clipper and projector built as a deep pipeline.
// Depends on lcp_pkg and lcp_div.
`timescale 1ns / 1ps
`default_nettype none

module line_clip_and_project import lcp_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  lcp_in_t       in_item_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output lcp_out_t      out_item_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [TW-1:0] cfg_data_i
);

  logic           en;
  logic [TW-1:0]  fov_q;
  ctx_t           c0_d, c0_q, c2_d, c2_q, c4_d, c4_q, c6_d, c6_q;
  ctx_t           c8_d, c8_q, c10_d, c10_q, c12_d, c12_q;
  logic           v0_q, v2_q, v4_q, v6_q, v8_q, v10_q, v12_q, ovld_q;
  lane_t [NLANE-1:0] lnA, lnB, lnC, lnD, lnE, lnF, lnG;
  logic           vA, vB, vC, vD, vE, vF, vG;
  ctx_t           cA, cB, cC, cD, cE, cF, cG;
  q_t [NLANE-1:0] qA, qB, qC, qD, qE, qF, qG;
  lcp_out_t       out_d, out_q;

  // The pipeline moves unless a finished result is held.
  assign en          = !ovld_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign cfg_ready_o = 1'b1;

  // Field-of-view register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fov_q <= FOV_RESET;
    end else if (cfg_valid_i) begin
      fov_q <= cfg_data_i;
    end
  end

  // Entry: differences, depth classes and the near/far reject test.
  always_comb begin
    c0_d          = '0;
    c0_d.pt[0].x  = in_item_i.start_x;
    c0_d.pt[0].y  = in_item_i.start_y;
    c0_d.pt[0].z  = in_item_i.start_z;
    c0_d.pt[1].x  = in_item_i.end_x;
    c0_d.pt[1].y  = in_item_i.end_y;
    c0_d.pt[1].z  = in_item_i.end_z;
    c0_d.dv[0].x  = qsub(in_item_i.end_x, in_item_i.start_x);
    c0_d.dv[0].y  = qsub(in_item_i.end_y, in_item_i.start_y);
    c0_d.dv[0].z  = qsub(in_item_i.end_z, in_item_i.start_z);
    c0_d.dv[1].x  = qsub(in_item_i.start_x, in_item_i.end_x);
    c0_d.dv[1].y  = qsub(in_item_i.start_y, in_item_i.end_y);
    c0_d.dv[1].z  = qsub(in_item_i.start_z, in_item_i.end_z);
    c0_d.zn[0]    = in_item_i.start_z > Z_NEAR;
    c0_d.zn[1]    = in_item_i.end_z > Z_NEAR;
    c0_d.zf[0]    = in_item_i.start_z < Z_FAR;
    c0_d.zf[1]    = in_item_i.end_z < Z_FAR;
    c0_d.ok       = !((c0_d.zn[0] && c0_d.zn[1]) || (c0_d.zf[0] && c0_d.zf[1]));
    c0_d.t        = fov_q;
    c0_d.last     = in_item_i.last_line;
  end

  // Depth-plane parameter for each endpoint.
  always_comb begin
    lnA = '0;
    for (int e = 0; e < 2; e++) begin
      lnA[e].num = qsub(c0_q.zn[e] ? Z_NEAR : Z_FAR, c0_q.pt[e].z);
      lnA[e].den = c0_q.dv[e].z;
    end
  end

  lcp_div u_div_a (.clk_i, .rst_ni, .en_i(en), .vld_i(v0_q), .ctx_i(c0_q), .lane_i(lnA),
                   .vld_o(vA), .ctx_o(cA), .quo_o(qA));

  // Products for the depth-plane crossing point.
  always_comb begin
    c2_d = cA;
    for (int e = 0; e < 2; e++) begin
      c2_d.tmp[e] = qA[e];
      c2_d.pa[e]  = qprod(qA[e], cA.dv[e].x);
      c2_d.pb[e]  = qprod(qA[e], cA.dv[e].y);
    end
  end

  // Perspective divide, or the crossing point scaled by the plane depth.
  always_comb begin
    for (int e = 0; e < 2; e++) begin
      if (!c2_q.zn[e] && !c2_q.zf[e]) begin
        lnB[2*e].num   = qneg(c2_q.pt[e].x);
        lnB[2*e].den   = c2_q.pt[e].z;
        lnB[2*e+1].num = qneg(c2_q.pt[e].y);
        lnB[2*e+1].den = c2_q.pt[e].z;
      end else begin
        lnB[2*e].num   = qadd(c2_q.pt[e].x, qmf(c2_q.pa[e]));
        lnB[2*e].den   = c2_q.zn[e] ? Q_ONE : FAR_DIV;
        lnB[2*e+1].num = qadd(c2_q.pt[e].y, qmf(c2_q.pb[e]));
        lnB[2*e+1].den = c2_q.zn[e] ? Q_ONE : FAR_DIV;
      end
    end
  end

  lcp_div u_div_b (.clk_i, .rst_ni, .en_i(en), .vld_i(v2_q), .ctx_i(c2_q), .lane_i(lnB),
                   .vld_o(vB), .ctx_o(cB), .quo_o(qB));

  // Side-plane test and products for the side crossing.
  always_comb begin
    q_t tt;
    q_t k;
    c4_d = cB;
    tt   = tq(cB.t);
    for (int e = 0; e < 2; e++) begin
      c4_d.cx[e] = qB[2*e];
      c4_d.cy[e] = qB[2*e+1];
    end
    c4_d.ok = cB.ok && !both_out(c4_d.cx[0], c4_d.cx[1], tt);
    for (int e = 0; e < 2; e++) begin
      c4_d.cl[e] = outside(c4_d.cx[e], tt);
      c4_d.kp[e] = c4_d.cx[e] > tt;
      k          = kval(c4_d.kp[e], tt);
      c4_d.pa[e] = qprod(k, cB.pt[e].z);
      c4_d.pb[e] = qprod(k, cB.dv[e].z);
    end
  end

  // Side crossing parameter, or x scaled by the tangent.
  always_comb begin
    lnC = '0;
    for (int e = 0; e < 2; e++) begin
      if (c4_q.cl[e]) begin
        lnC[e].num = qneg(qadd(c4_q.pt[e].x, qmf(c4_q.pa[e])));
        lnC[e].den = qadd(c4_q.dv[e].x, qmf(c4_q.pb[e]));
      end else begin
        lnC[e].num = c4_q.cx[e];
        lnC[e].den = tq(c4_q.t);
      end
    end
  end

  lcp_div u_div_c (.clk_i, .rst_ni, .en_i(en), .vld_i(v4_q), .ctx_i(c4_q), .lane_i(lnC),
                   .vld_o(vC), .ctx_o(cC), .quo_o(qC));

  always_comb begin
    c6_d = cC;
    for (int e = 0; e < 2; e++) begin
      c6_d.tmp[e] = qC[e];
      c6_d.pa[e]  = qprod(qC[e], cC.dv[e].y);
      c6_d.pb[e]  = qprod(qC[e], cC.dv[e].z);
    end
  end

  // Projected y at the side crossing.
  always_comb begin
    lnD = '0;
    for (int e = 0; e < 2; e++) begin
      lnD[e].num = qneg(qadd(c6_q.pt[e].y, qmf(c6_q.pa[e])));
      lnD[e].den = qadd(c6_q.pt[e].z, qmf(c6_q.pb[e]));
    end
  end

  lcp_div u_div_d (.clk_i, .rst_ni, .en_i(en), .vld_i(v6_q), .ctx_i(c6_q), .lane_i(lnD),
                   .vld_o(vD), .ctx_o(cD), .quo_o(qD));

  // Close the side stage, then test the top and bottom planes.
  always_comb begin
    q_t tt;
    q_t k;
    c8_d = cD;
    tt   = tq(cD.t);
    for (int e = 0; e < 2; e++) begin
      if (cD.cl[e]) begin
        c8_d.cy[e] = qD[e];
        c8_d.cx[e] = cD.kp[e] ? Q_ONE : -Q_ONE;
      end else begin
        c8_d.cx[e] = cD.tmp[e];
      end
    end
    c8_d.ok = cD.ok && !both_out(c8_d.cy[0], c8_d.cy[1], tt);
    for (int e = 0; e < 2; e++) begin
      c8_d.cl[e] = outside(c8_d.cy[e], tt);
      c8_d.kp[e] = c8_d.cy[e] > tt;
      k          = kval(c8_d.kp[e], tt);
      c8_d.pa[e] = qprod(k, cD.pt[e].z);
      c8_d.pb[e] = qprod(k, cD.dv[e].z);
    end
  end

  // Vertical crossing parameter, or y scaled by the tangent.
  always_comb begin
    lnE = '0;
    for (int e = 0; e < 2; e++) begin
      if (c8_q.cl[e]) begin
        lnE[e].num = qneg(qadd(c8_q.pt[e].y, qmf(c8_q.pa[e])));
        lnE[e].den = qadd(c8_q.dv[e].y, qmf(c8_q.pb[e]));
      end else begin
        lnE[e].num = c8_q.cy[e];
        lnE[e].den = tq(c8_q.t);
      end
    end
  end

  lcp_div u_div_e (.clk_i, .rst_ni, .en_i(en), .vld_i(v8_q), .ctx_i(c8_q), .lane_i(lnE),
                   .vld_o(vE), .ctx_o(cE), .quo_o(qE));

  always_comb begin
    c10_d = cE;
    for (int e = 0; e < 2; e++) begin
      c10_d.tmp[e] = qE[e];
      c10_d.pa[e]  = qprod(qE[e], cE.dv[e].x);
      c10_d.pb[e]  = qprod(qE[e], cE.dv[e].z);
    end
  end

  // Projected x at the vertical crossing.
  always_comb begin
    lnF = '0;
    for (int e = 0; e < 2; e++) begin
      lnF[e].num = qneg(qadd(c10_q.pt[e].x, qmf(c10_q.pa[e])));
      lnF[e].den = qadd(c10_q.pt[e].z, qmf(c10_q.pb[e]));
    end
  end

  lcp_div u_div_f (.clk_i, .rst_ni, .en_i(en), .vld_i(v10_q), .ctx_i(c10_q), .lane_i(lnF),
                   .vld_o(vF), .ctx_o(cF), .quo_o(qF));

  always_comb begin
    c12_d = cF;
    for (int e = 0; e < 2; e++) begin
      if (cF.cl[e]) begin
        c12_d.cx[e] = qF[e];
      end
    end
  end

  // Scale the projected x by the tangent.
  always_comb begin
    lnG = '0;
    for (int e = 0; e < 2; e++) begin
      lnG[e].num = c12_q.cx[e];
      lnG[e].den = tq(c12_q.t);
    end
  end

  lcp_div u_div_g (.clk_i, .rst_ni, .en_i(en), .vld_i(v12_q), .ctx_i(c12_q), .lane_i(lnG),
                   .vld_o(vG), .ctx_o(cG), .quo_o(qG));

  // Final endpoints; a rejected segment reports zeros.
  always_comb begin
    q_t [1:0] fx;
    q_t [1:0] fy;
    for (int e = 0; e < 2; e++) begin
      if (cG.cl[e]) begin
        fx[e] = qG[e];
        fy[e] = cG.kp[e] ? Q_ONE : -Q_ONE;
      end else begin
        fx[e] = cG.cx[e];
        fy[e] = cG.tmp[e];
      end
    end
    out_d.visible   = cG.ok;
    out_d.out_x0    = cG.ok ? fx[0] : 32'sd0;
    out_d.out_y0    = cG.ok ? fy[0] : 32'sd0;
    out_d.out_x1    = cG.ok ? fx[1] : 32'sd0;
    out_d.out_y1    = cG.ok ? fy[1] : 32'sd0;
    out_d.batch_end = cG.last;
  end

  // Valid bits between the divider passes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v2_q   <= 1'b0;
      v4_q   <= 1'b0;
      v6_q   <= 1'b0;
      v8_q   <= 1'b0;
      v10_q  <= 1'b0;
      v12_q  <= 1'b0;
      ovld_q <= 1'b0;
    end else if (en) begin
      v0_q   <= in_valid_i;
      v2_q   <= vA;
      v4_q   <= vB;
      v6_q   <= vC;
      v8_q   <= vD;
      v10_q  <= vE;
      v12_q  <= vF;
      ovld_q <= vG;
    end
  end

  // Context registers between the divider passes.
  always_ff @(posedge clk_i) begin
    if (en) begin
      c0_q  <= c0_d;
      c2_q  <= c2_d;
      c4_q  <= c4_d;
      c6_q  <= c6_d;
      c8_q  <= c8_d;
      c10_q <= c10_d;
      c12_q <= c12_d;
      out_q <= out_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

[design/lcp_div.sv]
// Pipelined four-lane Q16.16 divider, one quotient bit per stage, with context passthrough.
// Depends on lcp_pkg for the lane, flag and context types.
`timescale 1ns / 1ps
`default_nettype none

module lcp_div import lcp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   vld_i,
  input  ctx_t                   ctx_i,
  input  lane_t [NLANE-1:0]      lane_i,
  output logic                   vld_o,
  output ctx_t                   ctx_o,
  output q_t [NLANE-1:0]         quo_o
);

  lane_t [NLANE-1:0]                        in_q;
  ctx_t                                     cin_q;
  logic                                     vin_q;
  logic [DIV_STEPS:0]                       vst_q;
  ctx_t [DIV_STEPS:0]                       cst_q;
  logic [DIV_STEPS:0][NLANE-1:0][31:0]      rem_q, rem_d;
  logic [DIV_STEPS:0][NLANE-1:0][31:0]      low_q, low_d;
  logic [DIV_STEPS:0][NLANE-1:0][31:0]      quo_q, quo_d;
  logic [DIV_STEPS:0][NLANE-1:0][31:0]      dvs_q, dvs_d;
  dmeta_t [DIV_STEPS:0][NLANE-1:0]          meta_q, meta_d;
  q_t [NLANE-1:0]                           res_d, out_q;
  ctx_t                                     cout_q;
  logic                                     vout_q;

  // Magnitudes, special cases and the restoring division steps.
  always_comb begin : p_steps
    logic [31:0] na;
    logic [31:0] da;
    logic [32:0] t33;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    meta_d = meta_q;
    for (int l = 0; l < NLANE; l++) begin
      na = in_q[l].num[31] ? 32'(-in_q[l].num) : 32'(in_q[l].num);
      da = in_q[l].den[31] ? 32'(-in_q[l].den) : 32'(in_q[l].den);
      meta_d[0][l].neg  = in_q[l].num[31] ^ in_q[l].den[31];
      meta_d[0][l].dz   = (in_q[l].den == 32'sd0);
      meta_d[0][l].ovf  = ({16'd0, na[31:16]} >= da);
      meta_d[0][l].apos = !in_q[l].num[31] && (in_q[l].num != 32'sd0);
      meta_d[0][l].aneg = in_q[l].num[31];
      rem_d[0][l] = {16'd0, na[31:16]};
      low_d[0][l] = {na[15:0], 16'd0};
      quo_d[0][l] = '0;
      dvs_d[0][l] = da;
    end
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int l = 0; l < NLANE; l++) begin
        t33 = {rem_q[k][l], low_q[k][l][31]};
        if (t33 >= {1'b0, dvs_q[k][l]}) begin
          rem_d[k+1][l] = 32'(t33 - {1'b0, dvs_q[k][l]});
          quo_d[k+1][l] = {quo_q[k][l][30:0], 1'b1};
        end else begin
          rem_d[k+1][l] = t33[31:0];
          quo_d[k+1][l] = {quo_q[k][l][30:0], 1'b0};
        end
        low_d[k+1][l]  = {low_q[k][l][30:0], 1'b0};
        dvs_d[k+1][l]  = dvs_q[k][l];
        meta_d[k+1][l] = meta_q[k][l];
      end
    end
  end

  // Sign the quotient and saturate it.
  always_comb begin : p_final
    dmeta_t      m;
    logic [31:0] q;
    for (int l = 0; l < NLANE; l++) begin
      m = meta_q[DIV_STEPS][l];
      q = quo_q[DIV_STEPS][l];
      if (m.dz) begin
        res_d[l] = m.apos ? Q_MAX : (m.aneg ? Q_MIN : 32'sd0);
      end else if (m.ovf) begin
        res_d[l] = m.neg ? Q_MIN : Q_MAX;
      end else if (m.neg) begin
        res_d[l] = (q > 32'h8000_0000) ? Q_MIN : q_t'(32'd0 - q);
      end else begin
        res_d[l] = q[31] ? Q_MAX : q_t'(q);
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q  <= 1'b0;
      vst_q  <= '0;
      vout_q <= 1'b0;
    end else if (en_i) begin
      vin_q  <= vld_i;
      vst_q  <= {vst_q[DIV_STEPS-1:0], vin_q};
      vout_q <= vst_q[DIV_STEPS];
    end
  end

  // Data path registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      in_q   <= lane_i;
      cin_q  <= ctx_i;
      cst_q  <= {cst_q[DIV_STEPS-1:0], cin_q};
      rem_q  <= rem_d;
      low_q  <= low_d;
      quo_q  <= quo_d;
      dvs_q  <= dvs_d;
      meta_q <= meta_d;
      out_q  <= res_d;
      cout_q <= cst_q[DIV_STEPS];
    end
  end

  assign vld_o = vout_q;
  assign ctx_o = cout_q;
  assign quo_o = out_q;

endmodule

`default_nettype wire

[design/lcp_chk.sv]
// Port-level checker for line_clip_and_project, bound to the top level.
// Depends on lcp_pkg for the item structs.
`timescale 1ns / 1ps
`default_nettype none

module lcp_chk import lcp_pkg::*; (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_stall_o,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input lcp_out_t      out_item_o,
  input logic          cfg_valid_i,
  input logic          cfg_ready_o
);

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result item changed under stall");

  // A rejected segment carries zero coordinates.
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.visible |->
      (out_item_o.out_x0 == 32'sd0 && out_item_o.out_y0 == 32'sd0 &&
       out_item_o.out_x1 == 32'sd0 && out_item_o.out_y1 == 32'sd0))
    else $error("rejected segment with nonzero coordinates");

  // A held result freezes the pipeline, so no item is taken.
  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("item accepted while result held");

  // With no result waiting the input is open.
  a_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // The tangent register takes a write in any cycle.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("tangent write refused");

endmodule

bind line_clip_and_project lcp_chk u_lcp_chk (.*);

`default_nettype wire
